>>> sv/tksk_pkg.sv
// ----------------------------------------------------------------------------
// tksk_pkg
// Shared constants, codes and types of the top-k score keeper.
// ----------------------------------------------------------------------------
package tksk_pkg;

  localparam int unsigned SLOTS            = 64;
  localparam int unsigned SLOT_W           = $clog2(SLOTS);
  localparam int unsigned CNT_W            = $clog2(SLOTS + 1);
  localparam int unsigned KEEP_RESET       = 12;
  localparam int unsigned KEY_LETTERS      = 24;
  localparam int unsigned LETTER_W         = 5;
  localparam int unsigned LETTERS_PER_WORD = 12;
  localparam int unsigned KW_W             = LETTER_W * LETTERS_PER_WORD;
  localparam int unsigned SCORE_W          = 32;
  localparam int unsigned STRAT_W          = 2;
  localparam int unsigned INTR_W           = 5;
  localparam int unsigned PERIOD_W         = 5;
  localparam int unsigned KEEP_W           = 7;

  localparam int unsigned IN_DATA_W  = 168;
  localparam int unsigned OUT_DATA_W = 184;

  typedef enum logic [1:0] {
    OP_CONSIDER = 2'd0,
    OP_CLEAR    = 2'd1,
    OP_DRAIN    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_CONSIDER = 2'd0,
    KIND_CLEAR    = 2'd1,
    KIND_DRAINED  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_SCAN,
    ST_DSCAN,
    ST_DEMIT,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [KW_W-1:0]     kw_hi;
    logic [KW_W-1:0]     kw_lo;
    logic [PERIOD_W-1:0] period;
    logic [INTR_W-1:0]   interruptor;
    logic [STRAT_W-1:0]  strategy;
  } payload_t;

  // Keep the letters of one keyword word whose position lies below letters.
  function automatic logic [KW_W-1:0] mask_letters(input logic [KW_W-1:0] kw,
                                                   input logic [4:0]      letters,
                                                   input logic [4:0]      base);
    logic [KW_W-1:0] res;
    logic [5:0]      pos;
    res = '0;
    for (int j = 0; j < LETTERS_PER_WORD; j++) begin
      pos = 6'(base) + 6'(j);
      if (pos < 6'(letters)) begin
        res[LETTER_W*j +: LETTER_W] = kw[LETTER_W*j +: LETTER_W];
      end
    end
    return res;
  endfunction

endpackage

>>> sv/top_k_score_keeper_core.sv
// ----------------------------------------------------------------------------
// top_k_score_keeper_core
// Consider: into a store that is not yet full the item is written at accept; else
// it is compared with the worst slot and written there if higher. A rescan for the
// new worst slot follows such a win or a write that fills the store. Drain: n
// results, each after a pass over the score memory, whose single read port reads
// one slot a cycle. Clear and empty drain go straight to their response. One item
// at a time; the next can be taken in the cycle after its last result is loaded.
// Reset clears counts and worst slot, keep_count to 12, not the entry memories.
// ----------------------------------------------------------------------------
module top_k_score_keeper_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config: keep_count
  input  logic                                cfg_we_i,
  input  logic [tksk_pkg::KEEP_W-1:0]         cfg_wdata_i,
  // input items
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // score[31:0], strategy[33:32], interruptor[38:34], period[43:39],
  // keyword_lo[103:44], keyword_hi[163:104], zero fill
  input  logic [tksk_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // operation[1:0]
  input  logic [1:0]                          s_axis_tuser_i,
  // result items
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // accepted[0], slot[6:1], kept[13:7], entry_score[45:14], entry_strategy[47:46],
  // entry_interruptor[52:48], entry_period[57:53], entry_keyword_lo[117:58],
  // entry_keyword_hi[177:118], entry_valid[178], zero fill
  output logic [tksk_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  // kind[1:0]
  output logic [1:0]                          m_axis_tuser_o,
  output logic                                m_axis_tlast_o
);

  localparam int unsigned SW = tksk_pkg::SLOT_W;
  localparam int unsigned CW = tksk_pkg::CNT_W;

  // entry memories
  logic signed [tksk_pkg::SCORE_W-1:0] score_mem [tksk_pkg::SLOTS];
  tksk_pkg::payload_t                  pl_mem    [tksk_pkg::SLOTS];

  tksk_pkg::state_e state_q, state_d;

  logic [tksk_pkg::KEEP_W-1:0] keep_q;
  logic [CW-1:0]               keep_eff;
  logic [CW-1:0]               held_q, held_d;
  logic [SW-1:0]               worst_q, worst_d;

  logic signed [tksk_pkg::SCORE_W-1:0] in_score_q, in_score_d;
  tksk_pkg::payload_t                  in_pl_q, in_pl_d, pl_in;

  tksk_pkg::kind_e res_kind_q, res_kind_d;
  logic            res_acc_q, res_acc_d;
  logic [SW-1:0]   res_slot_q, res_slot_d;

  logic [CW-1:0] scan_cnt_q, scan_cnt_d;
  logic          rd_pend_q, rd_pend_d;
  logic [SW-1:0] rd_slot_q, rd_slot_d;
  logic          best_vld_q, best_vld_d;
  logic signed [tksk_pkg::SCORE_W-1:0] best_score_q, best_score_d;
  logic [SW-1:0] best_slot_q, best_slot_d;
  logic          prev_vld_q, prev_vld_d;
  logic signed [tksk_pkg::SCORE_W-1:0] prev_score_q, prev_score_d;
  logic [SW-1:0] prev_slot_q, prev_slot_d;
  logic [CW-1:0] emit_cnt_q, emit_cnt_d;

  // memory ports
  logic                                mem_we;
  logic [SW-1:0]                       mem_waddr;
  logic signed [tksk_pkg::SCORE_W-1:0] mem_wscore;
  tksk_pkg::payload_t                  mem_wpl;
  logic                                sc_re;
  logic [SW-1:0]                       sc_raddr;
  logic signed [tksk_pkg::SCORE_W-1:0] score_rd_q;
  logic                                pl_re;
  logic [SW-1:0]                       pl_raddr;
  tksk_pkg::payload_t                  pl_rd_q;

  // output register
  logic                                out_valid_q, out_valid_d;
  logic [tksk_pkg::OUT_DATA_W-1:0]     out_data_q, out_data_d;
  tksk_pkg::kind_e                     out_kind_q, out_kind_d;
  logic                                out_last_q, out_last_d;

  logic          s_fire;
  tksk_pkg::op_e op;
  logic          fill_ok;
  logic          fill_full;
  logic          scan_done;
  logic          scan_issue;
  logic          out_free;
  logic          cmp_win;
  logic          drain_last;
  logic          elig;
  logic [4:0]    letters;

  assign s_axis_tready_o = (state_q == tksk_pkg::ST_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign op              = tksk_pkg::op_e'(s_axis_tuser_i);

  assign keep_eff = (keep_q == '0) ? CW'(1) :
                    (keep_q > tksk_pkg::KEEP_W'(tksk_pkg::SLOTS)) ? CW'(tksk_pkg::SLOTS) :
                    CW'(keep_q);

  assign fill_ok    = (held_q < keep_eff);
  assign fill_full  = ((held_q + CW'(1)) >= keep_eff);
  assign scan_issue = (scan_cnt_q < held_q);
  assign scan_done  = (scan_cnt_q == held_q) && !rd_pend_q;
  assign out_free   = !out_valid_q || m_axis_tready_i;
  assign cmp_win    = (in_score_q > score_rd_q);
  assign drain_last = ((emit_cnt_q + CW'(1)) == held_q);

  // drain order: next entry lies strictly below the previous one
  assign elig = !prev_vld_q || (score_rd_q < prev_score_q) ||
                ((score_rd_q == prev_score_q) && (rd_slot_q > prev_slot_q));

  // incoming payload with unused keyword letters zeroed
  always_comb begin
    logic [tksk_pkg::PERIOD_W-1:0] per;
    per     = s_axis_tdata_i[43:39];
    letters = (per < 5'(tksk_pkg::KEY_LETTERS)) ? per : 5'(tksk_pkg::KEY_LETTERS);
    pl_in.strategy    = s_axis_tdata_i[33:32];
    pl_in.interruptor = s_axis_tdata_i[38:34];
    pl_in.period      = per;
    pl_in.kw_lo       = tksk_pkg::mask_letters(s_axis_tdata_i[103:44], letters, 5'd0);
    pl_in.kw_hi       = tksk_pkg::mask_letters(s_axis_tdata_i[163:104], letters,
                                               5'(tksk_pkg::LETTERS_PER_WORD));
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tksk_pkg::ST_IDLE: begin
        if (s_fire) begin
          unique case (op)
            tksk_pkg::OP_CONSIDER: begin
              if (fill_ok) begin
                state_d = fill_full ? tksk_pkg::ST_SCAN : tksk_pkg::ST_RESP;
              end else begin
                state_d = tksk_pkg::ST_CMP;
              end
            end
            tksk_pkg::OP_CLEAR: state_d = tksk_pkg::ST_RESP;
            tksk_pkg::OP_DRAIN: begin
              state_d = (held_q == '0) ? tksk_pkg::ST_RESP : tksk_pkg::ST_DSCAN;
            end
            default: state_d = tksk_pkg::ST_IDLE;
          endcase
        end
      end
      tksk_pkg::ST_CMP:   state_d = cmp_win ? tksk_pkg::ST_SCAN : tksk_pkg::ST_RESP;
      tksk_pkg::ST_SCAN:  if (scan_done) state_d = tksk_pkg::ST_RESP;
      tksk_pkg::ST_DSCAN: if (scan_done) state_d = tksk_pkg::ST_DEMIT;
      tksk_pkg::ST_DEMIT: begin
        if (out_free) begin
          state_d = drain_last ? tksk_pkg::ST_IDLE : tksk_pkg::ST_DSCAN;
        end
      end
      tksk_pkg::ST_RESP:  if (out_free) state_d = tksk_pkg::ST_IDLE;
      default:            state_d = tksk_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    held_d       = held_q;
    worst_d      = worst_q;
    in_score_d   = in_score_q;
    in_pl_d      = in_pl_q;
    res_kind_d   = res_kind_q;
    res_acc_d    = res_acc_q;
    res_slot_d   = res_slot_q;
    scan_cnt_d   = '0;
    rd_pend_d    = 1'b0;
    rd_slot_d    = rd_slot_q;
    best_vld_d   = 1'b0;
    best_score_d = best_score_q;
    best_slot_d  = best_slot_q;
    prev_vld_d   = prev_vld_q;
    prev_score_d = prev_score_q;
    prev_slot_d  = prev_slot_q;
    emit_cnt_d   = emit_cnt_q;
    mem_we       = 1'b0;
    mem_waddr    = worst_q;
    mem_wscore   = in_score_q;
    mem_wpl      = in_pl_q;
    sc_re        = 1'b0;
    sc_raddr     = worst_q;
    pl_re        = 1'b0;
    pl_raddr     = best_slot_q;
    out_valid_d  = m_axis_tready_i ? 1'b0 : out_valid_q;
    out_data_d   = out_data_q;
    out_kind_d   = out_kind_q;
    out_last_d   = out_last_q;

    unique case (state_q)
      tksk_pkg::ST_IDLE: begin
        prev_vld_d = 1'b0;
        emit_cnt_d = '0;
        if (s_fire) begin
          in_score_d = s_axis_tdata_i[31:0];
          in_pl_d    = pl_in;
          res_acc_d  = 1'b0;
          res_slot_d = '0;
          unique case (op)
            tksk_pkg::OP_CONSIDER: begin
              res_kind_d = tksk_pkg::KIND_CONSIDER;
              if (fill_ok) begin
                mem_we     = 1'b1;
                mem_waddr  = held_q[SW-1:0];
                mem_wscore = s_axis_tdata_i[31:0];
                mem_wpl    = pl_in;
                res_acc_d  = 1'b1;
                res_slot_d = held_q[SW-1:0];
                held_d     = held_q + CW'(1);
              end else begin
                // fetch the worst score for the compare
                sc_re    = 1'b1;
                sc_raddr = worst_q;
              end
            end
            tksk_pkg::OP_CLEAR: begin
              res_kind_d = tksk_pkg::KIND_CLEAR;
              held_d     = '0;
              worst_d    = '0;
            end
            tksk_pkg::OP_DRAIN: res_kind_d = tksk_pkg::KIND_DRAINED;
            default: ;
          endcase
        end
      end
      tksk_pkg::ST_CMP: begin
        if (cmp_win) begin
          mem_we     = 1'b1;
          mem_waddr  = worst_q;
          res_acc_d  = 1'b1;
          res_slot_d = worst_q;
        end
      end
      tksk_pkg::ST_SCAN, tksk_pkg::ST_DSCAN: begin
        scan_cnt_d = scan_cnt_q;
        best_vld_d = best_vld_q;
        if (scan_issue) begin
          sc_re      = 1'b1;
          sc_raddr   = scan_cnt_q[SW-1:0];
          rd_slot_d  = scan_cnt_q[SW-1:0];
          rd_pend_d  = 1'b1;
          scan_cnt_d = scan_cnt_q + CW'(1);
        end
        if (rd_pend_q) begin
          if (state_q == tksk_pkg::ST_SCAN) begin
            // first minimum wins
            if (!best_vld_q || (score_rd_q < best_score_q)) begin
              best_vld_d   = 1'b1;
              best_score_d = score_rd_q;
              best_slot_d  = rd_slot_q;
            end
          end else if (elig && (!best_vld_q || (score_rd_q > best_score_q))) begin
            best_vld_d   = 1'b1;
            best_score_d = score_rd_q;
            best_slot_d  = rd_slot_q;
          end
        end
        if (scan_done) begin
          if (state_q == tksk_pkg::ST_SCAN) begin
            worst_d = best_slot_q;
          end else begin
            pl_re        = 1'b1;
            pl_raddr     = best_slot_q;
            prev_vld_d   = 1'b1;
            prev_score_d = best_score_q;
            prev_slot_d  = best_slot_q;
          end
        end
      end
      tksk_pkg::ST_DEMIT: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_kind_d            = tksk_pkg::KIND_DRAINED;
          out_last_d            = drain_last;
          out_data_d            = '0;
          out_data_d[6:1]       = prev_slot_q;
          out_data_d[13:7]      = held_q;
          out_data_d[45:14]     = prev_score_q;
          out_data_d[47:46]     = pl_rd_q.strategy;
          out_data_d[52:48]     = pl_rd_q.interruptor;
          out_data_d[57:53]     = pl_rd_q.period;
          out_data_d[117:58]    = pl_rd_q.kw_lo;
          out_data_d[177:118]   = pl_rd_q.kw_hi;
          out_data_d[178]       = 1'b1;
          emit_cnt_d            = emit_cnt_q + CW'(1);
        end
      end
      tksk_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_kind_d       = res_kind_q;
          out_last_d       = 1'b1;
          out_data_d       = '0;
          out_data_d[0]    = res_acc_q;
          out_data_d[6:1]  = res_slot_q;
          out_data_d[13:7] = held_q;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tksk_pkg::ST_IDLE;
      keep_q      <= tksk_pkg::KEEP_W'(tksk_pkg::KEEP_RESET);
      held_q      <= '0;
      worst_q     <= '0;
      scan_cnt_q  <= '0;
      rd_pend_q   <= 1'b0;
      best_vld_q  <= 1'b0;
      prev_vld_q  <= 1'b0;
      emit_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        keep_q <= cfg_wdata_i;
      end
      held_q      <= held_d;
      worst_q     <= worst_d;
      scan_cnt_q  <= scan_cnt_d;
      rd_pend_q   <= rd_pend_d;
      best_vld_q  <= best_vld_d;
      prev_vld_q  <= prev_vld_d;
      emit_cnt_q  <= emit_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    in_score_q   <= in_score_d;
    in_pl_q      <= in_pl_d;
    res_kind_q   <= res_kind_d;
    res_acc_q    <= res_acc_d;
    res_slot_q   <= res_slot_d;
    rd_slot_q    <= rd_slot_d;
    best_score_q <= best_score_d;
    best_slot_q  <= best_slot_d;
    prev_score_q <= prev_score_d;
    prev_slot_q  <= prev_slot_d;
    out_data_q   <= out_data_d;
    out_kind_q   <= out_kind_d;
    out_last_q   <= out_last_d;
  end

  // score memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      score_mem[mem_waddr] <= mem_wscore;
    end
    if (sc_re) begin
      score_rd_q <= score_mem[sc_raddr];
    end
  end

  // payload memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pl_mem[mem_waddr] <= mem_wpl;
    end
    if (pl_re) begin
      pl_rd_q <= pl_mem[pl_raddr];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule
